/* rtl/sobel_gradient_direction_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sobel gradient direction unit: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_DIRECTION_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_DIRECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* rtl/sgd_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel gradient direction package
// Widths, constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgd_pkg;

  // Field widths.
  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 11;
  localparam int ABS_W     = 10;
  localparam int SUM_W     = 10;
  localparam int SQR_W     = 20;
  localparam int SQ_W      = 22;
  localparam int MAG_W     = 11;
  localparam int DIR_W     = 2;
  localparam int OUT_POS_W = 10;
  localparam int CFG_W     = 11;
  localparam int DIM_W     = 13;
  localparam int LO_PROD_W = 25;
  localparam int HI_PROD_W = 28;
  localparam int CMP_W     = 29;

  // Q16 tangents of 22.5 and 67.5 degrees.
  localparam logic [14:0] TAN_LO_Q16 = 15'd27146;
  localparam logic [17:0] TAN_HI_Q16 = 18'd158218;

  // First trial bit of the square root: the highest even power below 2^21.
  localparam logic [SQ_W-1:0] SQRT_BIT0 = 22'h10_0000;

  // Smallest legal image dimension.
  localparam logic [DIM_W-1:0] MIN_DIM = 13'd3;

  // Configuration register indexes and reset values.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Direction bins.
  typedef enum logic [DIR_W-1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic grad;
    logic mul;
    logic sum;
    logic step;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic sqrt_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/sgd_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sgd_ctrl.sv */
// ----------------------------------------------------------------------------
// Sobel gradient direction controller
// Sequences one pixel through gradient, multiply, square root and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_gradient_direction_unit_macros.svh"

module sgd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sgd_pkg::dp_sts_t sts_i,
  output sgd_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAD,
    S_MUL,
    S_SUM,
    S_SQRT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  // Commands follow from the current state, gated by the input valid and status.
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.grad   = (state_q == S_GRAD);
    cmd_o.mul    = (state_q == S_MUL);
    cmd_o.sum    = (state_q == S_SUM);
    cmd_o.step   = (state_q == S_SQRT);
    cmd_o.load   = (state_q == S_DONE) && sts_i.emit && sts_i.out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_GRAD;
        end
      end
      S_GRAD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sts_i.sqrt_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.emit || sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the registered input stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = stall_q;

  // The input side is open only while the controller waits for a pixel.
  `SGD_ASSERT_IMPL(a_open_only_idle, clk_i, rst_ni, !in_stall_o, state_q == S_IDLE)
  // An accepted beat starts the gradient step and closes the input.
  `SGD_ASSERT_NEXT(a_accept_to_grad, clk_i, rst_ni, cmd_o.accept,
                   (state_q == S_GRAD) && in_stall_o)
  // The square root restarts from its top bit and is not done at once.
  `SGD_ASSERT_NEXT(a_sqrt_starts, clk_i, rst_ni, state_q == S_SUM,
                   (state_q == S_SQRT) && !sts_i.sqrt_last)
  // The last root step always leads to the output step.
  `SGD_ASSERT_NEXT(a_sqrt_ends, clk_i, rst_ni, (state_q == S_SQRT) && sts_i.sqrt_last,
                   state_q == S_DONE)

endmodule

/* rtl/sgd_datapath.sv */
// ----------------------------------------------------------------------------
// Sobel gradient direction datapath
// Line stores, 3x3 window, Sobel sums, squares, bit-serial root and binning.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgd_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sgd_pkg::PIX_W-1:0]      pixel_i,
  input  sgd_pkg::dp_cmd_t               cmd_i,
  output sgd_pkg::dp_sts_t               sts_o,
  input  logic                           cfg_wr_i,
  input  logic [sgd_pkg::DIM_W-1:0]      img_w_i,
  input  logic [sgd_pkg::DIM_W-1:0]      img_h_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [sgd_pkg::OUT_POS_W-1:0]  out_row_o,
  output logic [sgd_pkg::OUT_POS_W-1:0]  out_col_o,
  output logic [sgd_pkg::MAG_W-1:0]      magnitude_o,
  output logic [sgd_pkg::DIR_W-1:0]      direction_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Frame position counters and the captured position of the current pixel.
  logic [CW-1:0]                col_q, c_q;
  logic [RW-1:0]                row_q, r_q;
  logic [sgd_pkg::PIX_W-1:0]    pix_q;
  logic [sgd_pkg::DIM_W-1:0]    col_next, row_next;

  // Window: entries 0..2 hold the newest column, 3..5 the one before.
  logic [sgd_pkg::PIX_W-1:0]    win_q [6];
  logic [sgd_pkg::PIX_W-1:0]    top, mid;

  logic [sgd_pkg::SUM_W-1:0]    sum_r, sum_l, sum_t, sum_b;
  logic [sgd_pkg::GRAD_W-1:0]   gx, gy, gx_neg, gy_neg;
  logic [sgd_pkg::ABS_W-1:0]    ax_q, ay_q;
  logic                         gx_pos_q, gy_pos_q;

  logic [sgd_pkg::SQR_W-1:0]     gx2_q, gy2_q;
  logic [sgd_pkg::LO_PROD_W-1:0] plo_q;
  logic [sgd_pkg::HI_PROD_W-1:0] phi_q;

  logic [sgd_pkg::SQ_W-1:0]     rem_q, res_q, bit_q, trial;
  logic [sgd_pkg::CMP_W-1:0]    ay_sh, lo_ext, hi_ext;
  sgd_pkg::dir_e                dir_q, dir_d;

  logic                         emit, interior;
  logic [sgd_pkg::DIM_W-1:0]    row_m1, col_m1;

  logic                         out_valid_q;
  logic [sgd_pkg::OUT_POS_W-1:0] out_row_q, out_col_q;
  logic [sgd_pkg::MAG_W-1:0]    mag_q;
  sgd_pkg::dir_e                out_dir_q;

  // Line stores: older holds row r-2, newer holds row r-1 at each column.
  sgd_ram #(.WIDTH(sgd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grad),
    .waddr_i (c_q),
    .wdata_i (mid),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (top)
  );

  sgd_ram #(.WIDTH(sgd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grad),
    .waddr_i (c_q),
    .wdata_i (pix_q),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (mid)
  );

  // Raster position advance with wrap at row and frame end.
  assign col_next = sgd_pkg::DIM_W'(col_q) + 1'b1;
  assign row_next = sgd_pkg::DIM_W'(row_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (col_next >= img_w_i) begin
        col_q <= '0;
        row_q <= (row_next >= img_h_i) ? '0 : row_next[RW-1:0];
      end else begin
        col_q <= col_next[CW-1:0];
      end
    end
  end

  // Capture the accepted beat and its position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_i;
      c_q   <= col_q;
      r_q   <= row_q;
    end
  end

  // Window shift once the line store words are back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.grad) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= pix_q;
    end
  end

  // Sobel sums: right and left columns for Gx, top and bottom rows for Gy.
  assign sum_r = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, pix_q};
  assign sum_l = {2'b00, win_q[3]} + {1'b0, win_q[4], 1'b0} + {2'b00, win_q[5]};
  assign sum_t = {2'b00, win_q[3]} + {1'b0, win_q[0], 1'b0} + {2'b00, top};
  assign sum_b = {2'b00, win_q[5]} + {1'b0, win_q[2], 1'b0} + {2'b00, pix_q};
  assign gx     = {1'b0, sum_r} - {1'b0, sum_l};
  assign gy     = {1'b0, sum_t} - {1'b0, sum_b};
  assign gx_neg = -gx;
  assign gy_neg = -gy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      ax_q     <= gx[sgd_pkg::GRAD_W-1] ? gx_neg[sgd_pkg::ABS_W-1:0]
                                        : gx[sgd_pkg::ABS_W-1:0];
      ay_q     <= gy[sgd_pkg::GRAD_W-1] ? gy_neg[sgd_pkg::ABS_W-1:0]
                                        : gy[sgd_pkg::ABS_W-1:0];
      gx_pos_q <= !gx[sgd_pkg::GRAD_W-1] && (gx != '0);
      gy_pos_q <= !gy[sgd_pkg::GRAD_W-1] && (gy != '0);
    end
  end

  // Squares and the scaled tangent thresholds, each in its own multiplier.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      gx2_q <= {10'd0, ax_q} * {10'd0, ax_q};
      gy2_q <= {10'd0, ay_q} * {10'd0, ay_q};
      plo_q <= {15'd0, ax_q} * {10'd0, sgd_pkg::TAN_LO_Q16};
      phi_q <= {18'd0, ax_q} * {10'd0, sgd_pkg::TAN_HI_Q16};
    end
  end

  // Direction bin from the threshold compares and the gradient signs.
  assign ay_sh  = {3'd0, ay_q, 16'd0};
  assign lo_ext = {4'd0, plo_q};
  assign hi_ext = {1'b0, phi_q};

  always_comb begin
    if ((ax_q == '0) && (ay_q == '0)) begin
      dir_d = sgd_pkg::DIR_0;
    end else if (ay_sh < lo_ext) begin
      dir_d = sgd_pkg::DIR_0;
    end else if (ay_sh >= hi_ext) begin
      dir_d = sgd_pkg::DIR_90;
    end else if (gx_pos_q == gy_pos_q) begin
      dir_d = sgd_pkg::DIR_45;
    end else begin
      dir_d = sgd_pkg::DIR_135;
    end
  end

  // Bit-serial integer square root, one result bit per step.
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      rem_q <= {2'b00, gx2_q} + {2'b00, gy2_q};
      res_q <= '0;
      bit_q <= sgd_pkg::SQRT_BIT0;
      dir_q <= dir_d;
    end else if (cmd_i.step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Position of the centre pixel and whether it has a full neighborhood.
  assign emit     = (r_q != '0) && (c_q != '0);
  assign interior = (r_q > RW'(1)) && (c_q > CW'(1));
  assign row_m1   = sgd_pkg::DIM_W'(r_q) - 1'b1;
  assign col_m1   = sgd_pkg::DIM_W'(c_q) - 1'b1;

  // Output register: holds one result beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_row_q <= row_m1[sgd_pkg::OUT_POS_W-1:0];
      out_col_q <= col_m1[sgd_pkg::OUT_POS_W-1:0];
      mag_q     <= interior ? res_q[sgd_pkg::MAG_W-1:0] : '0;
      out_dir_q <= interior ? dir_q : sgd_pkg::DIR_0;
    end
  end

  // Status back to the controller.
  assign sts_o.emit      = emit;
  assign sts_o.sqrt_last = bit_q[0];
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign magnitude_o = mag_q;
  assign direction_o = out_dir_q;

endmodule

/* rtl/sobel_gradient_direction_unit.sv */
// ----------------------------------------------------------------------------
// Sobel gradient direction unit
// Streaming 3x3 Sobel magnitude and four-bin direction over a raster image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; once a pixel at row r >= 1 and column c >= 1
// arrives, one result beat describes the centre pixel at (r-1, c-1), with zero
// magnitude and direction when that centre lies on the top row or left column.
// Each pixel occupies the block from acceptance to the next acceptance: it reads
// both line stores, forms the Sobel sums, then the squares and threshold products
// and Gx^2+Gy^2, runs the one-bit-per-cycle square root and hands the result to
// the output register. The output register lets the next pixel enter while a
// result still waits downstream. Line stores need no clearing after reset. A
// write to either image size register restarts the frame at row 0, column 0;
// sizes outside 3..MAX are clamped.
`timescale 1ns / 1ps

module sobel_gradient_direction_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Pixel input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sgd_pkg::PIX_W-1:0]      pixel_i,
  // Result output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sgd_pkg::OUT_POS_W-1:0]  out_row_o,
  output logic [sgd_pkg::OUT_POS_W-1:0]  out_col_o,
  output logic [sgd_pkg::MAG_W-1:0]      magnitude_o,
  output logic [sgd_pkg::DIR_W-1:0]      direction_o,
  // Register port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [sgd_pkg::CFG_W-1:0] width_q, height_q;
  logic                      cfg_wr;
  logic [sgd_pkg::DIM_W-1:0] w_raw, h_raw, w_use, h_use;
  sgd_pkg::dp_cmd_t          cmd;
  sgd_pkg::dp_sts_t          sts;

  // Register writes complete in the access phase; the block is always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sgd_pkg::WIDTH_RESET;
      height_q <= sgd_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == sgd_pkg::REG_WIDTH) begin
        width_q <= pwdata[sgd_pkg::CFG_W-1:0];
      end else begin
        height_q <= pwdata[sgd_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == sgd_pkg::REG_HEIGHT) ? {21'd0, height_q} : {21'd0, width_q};

  // Sizes in use, clamped to the legal range.
  assign w_raw = sgd_pkg::DIM_W'(width_q);
  assign h_raw = sgd_pkg::DIM_W'(height_q);

  always_comb begin
    if (w_raw < sgd_pkg::MIN_DIM) begin
      w_use = sgd_pkg::MIN_DIM;
    end else if (w_raw > sgd_pkg::DIM_W'(MAX_WIDTH)) begin
      w_use = sgd_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_use = w_raw;
    end
    if (h_raw < sgd_pkg::MIN_DIM) begin
      h_use = sgd_pkg::MIN_DIM;
    end else if (h_raw > sgd_pkg::DIM_W'(MAX_HEIGHT)) begin
      h_use = sgd_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      h_use = h_raw;
    end
  end

  sgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_wr_i    (cfg_wr),
    .img_w_i     (w_use),
    .img_h_i     (h_use),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .magnitude_o (magnitude_o),
    .direction_o (direction_o)
  );

endmodule

/* dv/sobel_gradient_direction_unit_test.sv */
// ----------------------------------------------------------------------------
// Sobel gradient direction unit testbench
// Streams grey pixels through the unit under several image geometries and
// checks every result beat against a cycle-free model of the Sobel window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_gradient_direction_unit_test;
  import sgd_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_BEATS  = 480;

  // One expected result beat.
  typedef struct {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [MAG_W-1:0]     mag;
    dir_e                 dir;
  } gradient_t;

  // Content shapes for random pixel runs.
  typedef enum int {
    STYLE_NOISE,
    STYLE_EXTREMES,
    STYLE_SMOOTH
  } pixel_style_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OUT_POS_W-1:0] out_row_o;
  logic [OUT_POS_W-1:0] out_col_o;
  logic [MAG_W-1:0]     magnitude_o;
  logic [DIR_W-1:0]     direction_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [2:0]           paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Pixels waiting to be sent and gradients waiting to come back.
  logic [PIX_W-1:0] pixel_feed [$];
  gradient_t        pending_gradients [$];
  int unsigned      mismatches = 0;

  // Model state: register values, line stores, window and raster position.
  logic [CFG_W-1:0] width_setting  = WIDTH_RESET;
  logic [CFG_W-1:0] height_setting = HEIGHT_RESET;
  logic [PIX_W-1:0] older_line [MAX_DIM];
  logic [PIX_W-1:0] newer_line [MAX_DIM];
  logic [PIX_W-1:0] window [6] = '{default: '0};
  int unsigned      col_count = 0;
  int unsigned      row_count = 0;

  // Width 3, height 9: each row past the second yields one interior centre.
  // The windows cover a flat patch, vertical and horizontal edges, both
  // diagonals and full-scale steps.
  logic [PIX_W-1:0] directed_frame [27] = '{
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd255,
    8'd0,   8'd0,   8'd255,
    8'd0,   8'd0,   8'd255,
    8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255,
    8'd0,   8'd255, 8'd255
  };

  // Sender and receiver pacing.
  int unsigned burst_left = 1;
  int unsigned idle_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  logic [PIX_W-1:0] level = 8'd128;

  sobel_gradient_direction_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .magnitude_o (magnitude_o),
    .direction_o (direction_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Sizes outside the legal range fall back to the nearest limit.
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] value);
    if (value < 3) return 3;
    if (value > MAX_DIM) return MAX_DIM;
    return value;
  endfunction

  // Integer square root, one result bit per trial from the top down.
  function automatic int unsigned floor_sqrt(int unsigned value);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int k = 11; k >= 0; k--) begin
      trial = root | (1 << k);
      if (trial * trial <= value) root = trial;
    end
    return root;
  endfunction

  // Direction bin from the Q16 tangent compares and the gradient signs.
  function automatic dir_e gradient_bin(int gx, int gy);
    longint ax;
    longint ay;
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    if (ax == 0 && ay == 0) return DIR_0;
    if (ay * 65536 < longint'(TAN_LO_Q16) * ax) return DIR_0;
    if (ay * 65536 >= longint'(TAN_HI_Q16) * ax) return DIR_90;
    return ((gx > 0) == (gy > 0)) ? DIR_45 : DIR_135;
  endfunction

  // Advances the raster model by one pixel and queues the gradient it yields.
  function automatic void predict_gradient(logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    int               gx;
    int               gy;
    int unsigned      mag;
    dir_e             dir;
    gradient_t        res;
    w   = clamp_dim(width_setting);
    h   = clamp_dim(height_setting);
    c   = col_count;
    r   = row_count;
    top = older_line[c];
    mid = newer_line[c];
    if (r >= 1 && c >= 1) begin
      mag = 0;
      dir = DIR_0;
      // Only interior centres get a real gradient; the border reports zero.
      if (r >= 2 && c >= 2) begin
        gx = (int'(top) + 2 * int'(mid) + int'(pix))
           - (int'(window[3]) + 2 * int'(window[4]) + int'(window[5]));
        gy = (int'(window[3]) + 2 * int'(window[0]) + int'(top))
           - (int'(window[5]) + 2 * int'(window[2]) + int'(pix));
        mag = floor_sqrt(gx * gx + gy * gy);
        dir = gradient_bin(gx, gy);
      end
      res.row = OUT_POS_W'(r - 1);
      res.col = OUT_POS_W'(c - 1);
      res.mag = MAG_W'(mag);
      res.dir = dir;
      pending_gradients.push_back(res);
    end
    older_line[c] = mid;
    newer_line[c] = pix;
    window[3] = window[0];
    window[4] = window[1];
    window[5] = window[2];
    window[0] = top;
    window[1] = mid;
    window[2] = pix;
    if (c + 1 >= w) begin
      col_count = 0;
      row_count = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_count = c + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(pixel_style_e style);
    case (style)
      STYLE_EXTREMES: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      STYLE_SMOOTH: begin
        // Slow drift with an occasional step edge.
        if ($urandom_range(0, 15) == 0) level = PIX_W'($urandom_range(0, 255));
        else level = level + PIX_W'($urandom_range(0, 6)) - 8'd3;
        return level;
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Waits until the unit has drained, then lets any result-free pixel finish.
  task automatic wait_until_idle();
    while (pixel_feed.size() != 0 || in_valid_i || pending_gradients.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) width_setting = value;
    else height_setting = value;
    col_count = 0;
    row_count = 0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int unsigned count, input pixel_style_e style);
    wait_until_idle();
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    repeat (count) pixel_feed.push_back(make_pixel(style));
  endtask

  // Pixel sender: bursts of beats separated by random idle gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (idle_left != 0) begin
        in_valid_i <= 1'b0;
        idle_left--;
      end else if (pixel_feed.size() != 0) begin
        in_valid_i <= 1'b1;
        pixel_i    <= pixel_feed.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern switches between quiet, random and long runs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(16, 160);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 1);
        2: out_stall_i <= ($urandom_range(0, 7) == 0);
        default: out_stall_i <= ((stall_span % 48) < 30);
      endcase
    end
  end

  // Monitor: predict on each accepted pixel, compare each accepted result.
  always @(posedge clk_i) begin : monitor
    gradient_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_gradient(pixel_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_gradients.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result beat row %0d col %0d magnitude %0d direction %0d",
                     $realtime, out_row_o, out_col_o, magnitude_o, direction_o);
        end else begin
          want = pending_gradients.pop_front();
          if (out_row_o !== want.row || out_col_o !== want.col ||
              magnitude_o !== want.mag || direction_o !== want.dir) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch, want row %0d col %0d mag %0d dir %0d, got %0d %0d %0d %0d",
                       $realtime, want.row, want.col, want.mag, want.dir,
                       out_row_o, out_col_o, magnitude_o, direction_o);
          end
        end
      end
    end
  end

  // Stimulus: a directed frame, fixed geometry corners, then random phases.
  initial begin
    int unsigned      random_beats;
    int unsigned      count;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_until_idle();
    write_register(REG_WIDTH, 11'd3);
    write_register(REG_HEIGHT, 11'd9);
    foreach (directed_frame[i]) pixel_feed.push_back(directed_frame[i]);

    // Sizes below and above the legal range.
    run_phase(11'd0, 11'd2047, 40, STYLE_NOISE);
    run_phase(11'd2, 11'd1, 30, STYLE_EXTREMES);
    run_phase(11'd2047, 11'd1, 40, STYLE_NOISE);

    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      w     = CFG_W'($urandom_range(3, 12));
      h     = CFG_W'($urandom_range(3, 8));
      count = $urandom_range(12, 120);
      case ($urandom_range(0, 9))
        0: w = CFG_W'($urandom_range(0, 2));
        1: h = CFG_W'($urandom_range(0, 2));
        2: begin
          w     = CFG_W'($urandom_range(1025, 2047));
          count = $urandom_range(8, 40);
        end
        default: ;
      endcase
      run_phase(w, h, count, pixel_style_e'($urandom_range(0, 2)));
      random_beats += count;
    end

    wait_until_idle();
    if (mismatches == 0) begin
      $display("sobel_gradient_direction_unit_test: clean");
    end else begin
      $display("sobel_gradient_direction_unit_test: errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("sobel_gradient_direction_unit_test: errors");
    $finish;
  end

endmodule
